### rtl/bse_pkg.sv
// shared constants and types for the bubble sort engine
// no dependencies; used by the interfaces, the cell and the core
package bse_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int DATA_W    = 32;
   localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

   // one element moving through or held in the chain
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
   } link_type;

   // per-cycle command from the core to every cell
   typedef struct packed {
      logic insert;   // compare incoming word against the held one
      logic shift;    // move every held word one cell toward the output
   } cell_ctrl_type;

endpackage

### rtl/bse_req_if.sv
// input channel of the bubble sort engine: valid/ready plus one element
// depends on bse_pkg
interface bse_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [bse_pkg::DATA_W-1:0] value;
   logic                              last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink   (input valid, input value, input last_item, output ready);
endinterface

### rtl/bse_rsp_if.sv
// result channel of the bubble sort engine: valid/ready plus one sorted element
// depends on bse_pkg
interface bse_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [bse_pkg::DATA_W-1:0] sorted_value;
   logic                              last_result;
   logic                              overflow;

   modport source (output valid, output sorted_value, output last_result,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input last_result,
                   input overflow, output ready);
endinterface

### rtl/bse_cell.sv
// one cell of the sorting chain: keeps the smaller word, passes the larger right
// depends on bse_pkg
module bse_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  bse_pkg::cell_ctrl_type ctrl,
   input  bse_pkg::link_type      left_in,
   input  bse_pkg::link_type      right_in,
   output bse_pkg::link_type      held_out,
   output bse_pkg::link_type      pass_out
);

   bse_pkg::link_type held_ff, held_in;
   bse_pkg::link_type pass_ff, pass_in;

   always_comb begin
      held_in = held_ff;
      pass_in = '0;
      if (ctrl.shift) begin
         held_in = right_in;
      end else if (ctrl.insert && left_in.valid) begin
         if (!held_ff.valid) begin
            held_in = left_in;
         end else if ($signed(left_in.value) < $signed(held_ff.value)) begin
            held_in = left_in;
            pass_in = held_ff;
         end else begin
            pass_in = left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
         pass_ff.valid <= pass_in.valid;
      end
      held_ff.value <= held_in.value;
      pass_ff.value <= pass_in.value;
   end

   assign held_out = held_ff;
   assign pass_out = pass_ff;

endmodule

### rtl/bubble_sort_engine_core.sv
// top level of the bubble sort engine: load, settle and drain control around a cell chain
// depends on bse_pkg, bse_req_if, bse_rsp_if and bse_cell

// Collects a block of signed 32-bit words, one per accepted req word, until a
// word marked last_item arrives, then returns them on rsp in ascending signed
// order, smallest first, with last_result on the final word. Sorting happens
// while loading: each word enters a chain of MAX_ITEMS cells, and each cell
// keeps the smaller of what it holds and what arrives, passing the larger one
// cell to the right per cycle. Words load as req hands them over, then req
// stays low while the chain settles, until the last word has rippled to its
// slot, then the words drain one per cycle, while rsp takes them, from the
// head of the chain through an output register. Words beyond MAX_ITEMS in a
// block are dropped and every result of that block carries overflow; a
// dropped word marked last still ends the block. req is taken again as soon
// as the final result sits in the output register.
module bubble_sort_engine_core (
   input logic      clock,
   input logic      reset,
   bse_req_if.sink  req,
   bse_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      LOAD,
      SETTLE,
      DRAIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [bse_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                               overflow_ff, overflow_in;

   // output register
   logic                               out_valid_ff, out_valid_in;
   logic signed [bse_pkg::DATA_W-1:0]  out_value_ff, out_value_in;
   logic                               out_last_ff, out_last_in;
   logic                               out_ovf_ff, out_ovf_in;

   // chain wiring: pass[i] enters cell i, held[i] is cell i's word
   bse_pkg::link_type                  pass [bse_pkg::MAX_ITEMS+1];
   bse_pkg::link_type                  held [bse_pkg::MAX_ITEMS+1];
   bse_pkg::cell_ctrl_type             ctrl;

   logic                               req_fire;
   logic                               has_room;
   logic                               in_flight;
   logic                               drain_step;

   assign req.ready = (state_ff == LOAD);
   assign req_fire  = req.valid && req.ready;
   assign has_room  = (count_ff < bse_pkg::COUNT_W'(bse_pkg::MAX_ITEMS));

   // new word enters the head of the chain
   assign pass[0].valid = req_fire && has_room;
   assign pass[0].value = req.value;

   // nothing to the right of the last cell
   assign held[bse_pkg::MAX_ITEMS] = '0;

   // move a word out when the head holds one and the output register frees up
   assign drain_step = (state_ff == DRAIN) && held[0].valid &&
                       (!out_valid_ff || rsp.ready);

   assign ctrl.insert = (state_ff != DRAIN);
   assign ctrl.shift  = drain_step;

   for (genvar i = 0; i < bse_pkg::MAX_ITEMS; i++) begin : g_cell
      bse_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .left_in  (pass[i]),
         .right_in (held[i+1]),
         .held_out (held[i]),
         .pass_out (pass[i+1])
      );
   end

   // any word still rippling between cells
   always_comb begin
      in_flight = 1'b0;
      for (int i = 1; i <= bse_pkg::MAX_ITEMS; i++) begin
         in_flight = in_flight | pass[i].valid;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  count_in = count_ff + bse_pkg::COUNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req.last_item) begin
                  state_in = SETTLE;
               end
            end
         end
         SETTLE: begin
            if (!in_flight) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            if (drain_step) begin
               out_valid_in = 1'b1;
               out_value_in = held[0].value;
               out_last_in  = !held[1].valid;
               out_ovf_in   = overflow_ff;
               if (!held[1].valid) begin
                  // block done, ready for the next one
                  state_in    = LOAD;
                  count_in    = '0;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.sorted_value = out_value_ff;
   assign rsp.last_result  = out_last_ff;
   assign rsp.overflow     = out_ovf_ff;

`ifndef ASSERT_OFF
   // stored count never exceeds the chain length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bse_pkg::COUNT_W'(bse_pkg::MAX_ITEMS))
      else $error("element count above capacity");

   // occupied cells form an unbroken run from the head
   for (genvar i = 0; i < bse_pkg::MAX_ITEMS - 1; i++) begin : g_chk_packed
      a_packed: assert property (@(posedge clock) disable iff (reset)
         held[i+1].valid |-> held[i].valid)
         else $error("hole in the cell chain");
   end

   // the head word is no larger than the next one during drain
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DRAIN) && held[1].valid |->
         $signed(held[0].value) <= $signed(held[1].value))
      else $error("chain head out of order during drain");

   // nothing ripples during drain
   a_quiet_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DRAIN) |-> !in_flight)
      else $error("word still in flight while draining");

   // draining the final word returns control to loading and shows it as the last result
   a_last_to_load: assert property (@(posedge clock) disable iff (reset)
      drain_step && !held[1].valid |=> (state_ff == LOAD) && rsp.valid && rsp.last_result)
      else $error("final word did not end the block");
`endif

endmodule

### tb/sort_order_checker.sv
// watches the req and rsp channels of the bubble sort engine, predicts the sorted words
// of each block and compares every rsp word with the oldest prediction
// depends on bse_pkg, bse_req_if and bse_rsp_if
module sort_order_checker (
   input  logic clock,
   input  logic reset,
   bse_req_if   req_mon,
   bse_rsp_if   rsp_mon,
   output int   words_due,
   output int   mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import bse_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_result;
      logic                     overflow;
   } sorted_word_type;

   logic signed [DATA_W-1:0] block_words [MAX_ITEMS];
   int                       block_count;
   logic                     dropped_seen;
   sorted_word_type          sorted_words_due [$];

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: %s", $time, msg);
   endtask

   // sort the held block ascending (signed) and queue one word per element
   task automatic emit_sorted_block();
      int                       i;
      int                       j;
      logic signed [DATA_W-1:0] key;
      sorted_word_type          word;
      for (i = 1; i < block_count; i++) begin
         key = block_words[i];
         j = i - 1;
         while (j >= 0 && block_words[j] > key) begin
            block_words[j + 1] = block_words[j];
            j--;
         end
         block_words[j + 1] = key;
      end
      for (i = 0; i < block_count; i++) begin
         word.value       = block_words[i];
         word.last_result = (i == block_count - 1);
         word.overflow    = dropped_seen;
         sorted_words_due.push_back(word);
      end
      block_count  = 0;
      dropped_seen = 1'b0;
   endtask

   always @(posedge clock) begin : watch_channels
      sorted_word_type due;
      sorted_word_type seen;
      if (reset) begin
         block_count    = 0;
         dropped_seen   = 1'b0;
         mismatch_count = 0;
         sorted_words_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (block_count < MAX_ITEMS) begin
               block_words[block_count] = req_mon.value;
               block_count++;
            end else begin
               dropped_seen = 1'b1;
            end
            if (req_mon.last_item) begin
               emit_sorted_block();
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.value       = rsp_mon.sorted_value;
            seen.last_result = rsp_mon.last_result;
            seen.overflow    = rsp_mon.overflow;
            if (sorted_words_due.size() == 0) begin
               note_mismatch($sformatf("rsp word expected none actual %0d", seen.value));
            end else begin
               due = sorted_words_due.pop_front();
               if (seen.value !== due.value) begin
                  note_mismatch($sformatf("sorted_value expected %0d actual %0d",
                                          due.value, seen.value));
               end
               if (seen.last_result !== due.last_result) begin
                  note_mismatch($sformatf("last_result expected %0b actual %0b",
                                          due.last_result, seen.last_result));
               end
               if (seen.overflow !== due.overflow) begin
                  note_mismatch($sformatf("overflow expected %0b actual %0b",
                                          due.overflow, seen.overflow));
               end
            end
         end
      end
      words_due <= sorted_words_due.size();
   end

endmodule

### tb/bubble_sort_engine_core_test.sv
// top of the bubble sort engine testbench: clock, reset, req stimulus and rsp back-pressure
// depends on bse_pkg, bse_req_if, bse_rsp_if, bubble_sort_engine_core and sort_order_checker
module bubble_sort_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bse_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 8;
   localparam int ITEM_GOAL    = 420;
   // cap on the whole run, well above the slowest block plus receiver stalls
   localparam int CYCLE_LIMIT  = 200000;
   // settle plus drain of a full chain, with margin
   localparam int DRAIN_CYCLES = 3 * MAX_ITEMS + 20;
   localparam int LONG_HOLD    = 400;

   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MOST_POSITIVE = ~MOST_NEGATIVE;

   // directed blocks, back to back: lengths and their words in order
   localparam int DIRECTED_BLOCKS = 5;
   localparam int DIRECTED_WORDS  = 22;
   localparam int DIRECTED_LENS [DIRECTED_BLOCKS] = '{1, 2, 5, 8, 6};
   localparam logic signed [DATA_W-1:0] DIRECTED_VALUES [DIRECTED_WORDS] = '{
      MOST_NEGATIVE,                        // single-word block
      MOST_POSITIVE, MOST_NEGATIVE,         // two extremes, reversed
      0, -1, 1, 0, -1,                      // equal values around zero
      5, 4, 3, 2, 1, 0, -1, -2,             // strictly descending
      MOST_POSITIVE, MOST_POSITIVE, MOST_NEGATIVE, MOST_NEGATIVE,
      32'sh5555_5555, 32'shAAAA_AAAA        // alternating bit patterns
   };

   typedef enum {VALUES_WIDE, VALUES_NARROW, VALUES_EDGES} value_mix_type;
   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} ready_mode_type;

   logic clock = 1'b0;
   logic reset;

   int words_due;
   int mismatch_count;
   int words_sent    = 0;
   int burst_left    = 0;
   int hold_requests = 0;
   int cycle_count   = 0;

   bse_req_if req_ch ();
   bse_rsp_if rsp_ch ();

   bubble_sort_engine_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // scoreboard lives beside the block and reports back only the pending and mismatch counts
   sort_order_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .words_due      (words_due),
      .mismatch_count (mismatch_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // rsp back-pressure: a randomly redrawn mode, plus long hold-offs on request
   // that sit on a waiting result so req stalls while the block drains
   always @(posedge clock) begin : drive_ready
      logic                  next_ready;
      static ready_mode_type ready_mode = READY_ALWAYS;
      static int             mode_left  = 0;
      static int             hold_left  = 0;
      static int             holds_done = 0;
      if (reset) begin
         next_ready = 1'b0;
         mode_left  = 0;
         hold_left  = 0;
      end else if (hold_left > 0) begin
         next_ready = 1'b0;
         hold_left--;
      end else if (holds_done < hold_requests && rsp_ch.valid) begin
         // a result is waiting: sit on it for a long stretch
         next_ready = 1'b0;
         hold_left  = LONG_HOLD - 1;
         holds_done++;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(32, 200);
         end
         mode_left--;
         case (ready_mode)
            READY_ALWAYS: next_ready = 1'b1;
            READY_COIN:   next_ready = 1'($urandom_range(0, 1));
            READY_SPARSE: next_ready = (mode_left % 4 == 0);
            default:      next_ready = ($urandom_range(0, 7) != 0);
         endcase
      end
      rsp_ch.ready <= next_ready;
   end

   // value generator; narrow mixes give lots of duplicates
   function automatic logic signed [DATA_W-1:0] random_value(input value_mix_type mix);
      case (mix)
         VALUES_NARROW: return DATA_W'($urandom_range(0, 8)) - 4;
         VALUES_EDGES: begin
            case ($urandom_range(0, 5))
               0:       return MOST_NEGATIVE;
               1:       return MOST_POSITIVE;
               2:       return 0;
               3:       return -1;
               4:       return 1;
               default: return $urandom;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // mostly short blocks, some long, a few past capacity
   function automatic int pick_block_length(input int block_idx);
      int roll;
      case (block_idx)
         2:  return MAX_ITEMS;          // exactly full, no overflow
         4:  return MAX_ITEMS + 1;      // only the last word is dropped
         7:  return MAX_ITEMS + 6;      // several words dropped
         10: return 1;
         11: return 2;
         default: begin
            roll = $urandom_range(0, 99);
            if (roll < 60)      return $urandom_range(1, 8);
            else if (roll < 85) return $urandom_range(9, 32);
            else if (roll < 96) return $urandom_range(33, MAX_ITEMS);
            else                return $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
         end
      endcase
   endfunction

   // offer one word and hold it until accepted; called right after a rising edge.
   // bursts of random length with random gaps in between
   task automatic send_word(input logic signed [DATA_W-1:0] value, input logic last_item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.value     <= value;
      req_ch.last_item <= last_item;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   initial begin
      int            block_idx;
      int            block_len;
      int            next_word;
      int            k;
      value_mix_type mix;

      req_ch.valid     <= 1'b0;
      req_ch.value     <= '0;
      req_ch.last_item <= 1'b0;
      reset            <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed blocks: extremes, duplicates, reversed order
      next_word = 0;
      for (block_idx = 0; block_idx < DIRECTED_BLOCKS; block_idx++) begin
         for (k = 0; k < DIRECTED_LENS[block_idx]; k++) begin
            send_word(DIRECTED_VALUES[next_word], k == DIRECTED_LENS[block_idx] - 1);
            next_word++;
         end
      end

      // random blocks until the word budget is spent
      block_idx = 0;
      while (words_sent < ITEM_GOAL) begin
         // ask for a long rsp hold-off ahead of the full block and once more later
         if (block_idx == 2 || block_idx == 14) begin
            hold_requests <= hold_requests + 1;
         end
         block_len = pick_block_length(block_idx);
         mix       = value_mix_type'($urandom_range(0, 2));
         for (k = 0; k < block_len; k++) begin
            send_word(random_value(mix), k == block_len - 1);
         end
         block_idx++;
      end
      req_ch.valid <= 1'b0;

      // let the checker's pending count catch up with the final word
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && words_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
